// File: hw/rtl/usp_pkg.sv
package usp_pkg;

  // command codes
  localparam logic [3:0] CMD_QUERY     = 4'd0;
  localparam logic [3:0] CMD_DECREMENT = 4'd1;
  localparam logic [3:0] CMD_MARK_OK   = 4'd2;
  localparam logic [3:0] CMD_CLEAR     = 4'd3;
  localparam logic [3:0] CMD_SELECT    = 4'd4;
  localparam logic [3:0] CMD_REQ_ROLL  = 4'd5;
  localparam logic [3:0] CMD_ROLL_PEND = 4'd6;
  localparam logic [3:0] CMD_ROLL_NOW  = 4'd7;
  localparam logic [3:0] CMD_REVERT    = 4'd8;
  localparam logic [3:0] CMD_RESET_ALL = 4'd9;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_NO_TRIES  = 2'd2;
  localparam logic [1:0] ST_NO_CAND   = 2'd3;

  // datapath operations
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP         = 5'd0;
  localparam logic [OP_W-1:0] OP_LATCH       = 5'd1;
  localparam logic [OP_W-1:0] OP_EXEC        = 5'd2;
  localparam logic [OP_W-1:0] OP_RESET_ALL   = 5'd3;
  localparam logic [OP_W-1:0] OP_SEL_INIT    = 5'd4;
  localparam logic [OP_W-1:0] OP_SEL_STEP    = 5'd5;
  localparam logic [OP_W-1:0] OP_SEL_FIN     = 5'd6;
  localparam logic [OP_W-1:0] OP_ROLL_INIT   = 5'd7;
  localparam logic [OP_W-1:0] OP_ROLL_STEP   = 5'd8;
  localparam logic [OP_W-1:0] OP_ROLL_FIN    = 5'd9;
  localparam logic [OP_W-1:0] OP_REV_INIT    = 5'd10;
  localparam logic [OP_W-1:0] OP_REV_STEP    = 5'd11;
  localparam logic [OP_W-1:0] OP_REV_NOCAND  = 5'd12;
  localparam logic [OP_W-1:0] OP_REV_SHIFT   = 5'd13;
  localparam logic [OP_W-1:0] OP_REV_FIX_CUR = 5'd14;
  localparam logic [OP_W-1:0] OP_REV_FIX_NEW = 5'd15;
  localparam logic [OP_W-1:0] OP_SHOW_CUR    = 5'd16;
  localparam logic [OP_W-1:0] OP_BAD_TARGET  = 5'd17;
  localparam logic [OP_W-1:0] OP_REPORT      = 5'd18;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] cmd;     // latched command
    logic       idx_ok;  // latched index below slots in use
    logic       pend;    // roll request outstanding
    logic       tgt_ok;  // pending target below slots in use
    logic       last;    // walk pointer on last slot in use
    logic       found;   // search hit
  } dp_stat_t;

endpackage

// File: hw/rtl/usp_cmd_if.sv
interface usp_cmd_if;
  logic       valid;
  logic       ready;
  logic [3:0] cmd;
  logic [3:0] slot_index;

  modport source (output valid, output cmd, output slot_index, input ready);
  modport sink (input valid, input cmd, input slot_index, output ready);
endinterface

// File: hw/rtl/usp_rsp_if.sv
interface usp_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [2:0] result_slot;
  logic       slot_successful;
  logic [3:0] slot_tries_left;
  logic [2:0] slot_priority;
  logic [2:0] current_slot;
  logic       restart_pending;

  modport source (
    output valid, output status, output result_slot, output slot_successful,
    output slot_tries_left, output slot_priority, output current_slot,
    output restart_pending, input ready
  );
  modport sink (
    input valid, input status, input result_slot, input slot_successful,
    input slot_tries_left, input slot_priority, input current_slot,
    input restart_pending, output ready
  );
endinterface

// File: hw/rtl/update_slot_priority_manager.sv
// sequencing: simple commands and reset all go straight to the result word; select new,
//   a roll that goes ahead and a revert walk the slots in use, and a revert that finds a
//   fallback walks them a second time; walks step one slot a cycle through the single
//   table read port
// throughput: one command at a time, next word taken the cycle after the result loads
// reset: slot 0 current and successful, ranks in slot order, tries = 3, slot_count = 8,
//   max_tries = 3, no roll pending, no result word held
module update_slot_priority_manager #(
  parameter int SLOTS    = 8,
  parameter int TRY_BITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // command and result channels
  usp_cmd_if.sink     cmd_ch,
  usp_rsp_if.source   rsp_ch
);
  import usp_pkg::*;

  // configuration registers, word address picks the register
  logic [3:0] slot_count;
  logic [3:0] max_tries;
  logic       cfg_wr;

  dp_cmd_t  ctl;
  dp_stat_t st;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= 4'd8;
      max_tries  <= 4'd3;
    end else if (cfg_wr) begin
      // slot_count only takes effect at the next reset all
      if (paddr[2]) begin
        max_tries <= pwdata[3:0];
      end else begin
        slot_count <= pwdata[3:0];
      end
    end
  end

  assign prdata = paddr[2] ? {28'd0, max_tries} : {28'd0, slot_count};

  // sequencer: one state per walk, waits in report while the result word is held
  usp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_ch.valid),
    .in_ready  (cmd_ch.ready),
    .out_valid (rsp_ch.valid),
    .out_ready (rsp_ch.ready),
    .ctl       (ctl),
    .st        (st)
  );

  // slot table, walk pointer, search registers and the result word register
  usp_dp #(
    .SLOTS    (SLOTS),
    .TRY_BITS (TRY_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .st              (st),
    .cmd             (cmd_ch.cmd),
    .slot_index      (cmd_ch.slot_index),
    .slot_count      (slot_count),
    .max_tries       (max_tries),
    .status          (rsp_ch.status),
    .result_slot     (rsp_ch.result_slot),
    .slot_successful (rsp_ch.slot_successful),
    .slot_tries_left (rsp_ch.slot_tries_left),
    .slot_priority   (rsp_ch.slot_priority),
    .current_slot    (rsp_ch.current_slot),
    .restart_pending (rsp_ch.restart_pending)
  );

endmodule

// File: hw/rtl/usp_dp.sv
module usp_dp #(
  parameter int SLOTS    = 8,
  parameter int TRY_BITS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  usp_pkg::dp_cmd_t  ctl,
  output usp_pkg::dp_stat_t st,
  input  logic [3:0]        cmd,
  input  logic [3:0]        slot_index,
  input  logic [3:0]        slot_count,
  input  logic [3:0]        max_tries,
  output logic [1:0]        status,
  output logic [2:0]        result_slot,
  output logic              slot_successful,
  output logic [3:0]        slot_tries_left,
  output logic [2:0]        slot_priority,
  output logic [2:0]        current_slot,
  output logic              restart_pending
);
  import usp_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int AW = $clog2(SLOTS + 1);
  localparam logic [8:0] TRY_MAX = 9'((1 << TRY_BITS) - 1);
  localparam logic [TRY_BITS-1:0] RST_TRIES =
    (TRY_MAX < 9'd3) ? TRY_BITS'(TRY_MAX) : TRY_BITS'(3);
  localparam logic [AW-1:0] RST_ACTIVE = AW'((SLOTS < 8) ? SLOTS : 8);

  // slot table
  logic                flag  [SLOTS];
  logic [TRY_BITS-1:0] tries [SLOTS];
  logic [IW-1:0]       rank  [SLOTS];

  logic [IW-1:0] cur;
  logic          pend;
  logic [IW-1:0] pend_tgt;
  logic [AW-1:0] active;

  logic [3:0]    cmd_q;
  logic [3:0]    idx_q;
  logic [IW-1:0] ptr;
  logic [IW-1:0] pick;
  logic [IW-1:0] key;
  logic          found;

  logic [1:0]    res_status;
  logic [IW-1:0] res_slot;
  logic [2:0]    res_tag;
  logic          res_ok;

  logic [TRY_BITS-1:0] load_tries;
  logic [AW-1:0]       clamp_n;
  logic [IW-1:0]       lowest;
  logic [IW-1:0]       idx_lo;
  logic [IW-1:0]       roll_src;
  logic [IW-1:0]       rd_addr;
  logic                rd_flag;
  logic [TRY_BITS-1:0] rd_tries;
  logic [IW-1:0]       rd_rank;
  logic [IW-1:0]       ptr_next;

  always_comb begin
    load_tries = ({5'd0, max_tries} > TRY_MAX) ? TRY_BITS'(TRY_MAX) : TRY_BITS'(max_tries);
    if (slot_count < 4'd2) begin
      clamp_n = AW'(2);
    end else if (8'(slot_count) > 8'(SLOTS)) begin
      clamp_n = AW'(SLOTS);
    end else begin
      clamp_n = AW'(slot_count);
    end
    lowest   = IW'(active - AW'(1));
    idx_lo   = IW'(idx_q);
    roll_src = (cmd_q == CMD_ROLL_PEND) ? pend_tgt : idx_lo;
    ptr_next = st.last ? '0 : ptr + IW'(1);
  end

  // one read port into the table
  always_comb begin
    case (ctl.op)
      OP_EXEC:      rd_addr = idx_lo;
      OP_ROLL_INIT: rd_addr = roll_src;
      OP_REPORT:    rd_addr = res_slot;
      default:      rd_addr = ptr;
    endcase
    rd_flag  = flag[rd_addr];
    rd_tries = tries[rd_addr];
    rd_rank  = rank[rd_addr];
  end

  always_comb begin
    st.cmd    = cmd_q;
    st.idx_ok = 8'(idx_q) < 8'(active);
    st.pend   = pend;
    st.tgt_ok = 8'(pend_tgt) < 8'(active);
    st.last   = 8'(ptr) == (8'(active) - 8'd1);
    st.found  = found;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.op == OP_RESET_ALL) begin
      for (int i = 0; i < SLOTS; i++) begin
        flag[i]  <= (i == 0);
        tries[i] <= rst ? RST_TRIES : load_tries;
        rank[i]  <= IW'(i);
      end
      cur        <= '0;
      pend       <= 1'b0;
      pend_tgt   <= '0;
      active     <= rst ? RST_ACTIVE : clamp_n;
      res_status <= ST_OK;
      res_slot   <= '0;
      res_tag    <= '0;
      res_ok     <= 1'b1;
    end else begin
      case (ctl.op)
        OP_LATCH: begin
          cmd_q <= cmd;
          idx_q <= slot_index;
        end
        OP_EXEC: begin
          res_slot <= idx_lo;
          res_tag  <= 3'(idx_q);
          res_ok   <= st.idx_ok;
          if (!st.idx_ok) begin
            res_status <= ST_BAD_INDEX;
          end else begin
            case (cmd_q)
              CMD_DECREMENT: begin
                if (rd_tries == '0) begin
                  res_status <= ST_NO_TRIES;
                end else begin
                  res_status    <= ST_OK;
                  tries[idx_lo] <= rd_tries - TRY_BITS'(1);
                end
              end
              CMD_MARK_OK: begin
                res_status   <= ST_OK;
                flag[idx_lo] <= 1'b1;
              end
              CMD_CLEAR: begin
                // the system slot cannot be cleared
                if (idx_q == 4'd0) begin
                  res_status <= ST_BAD_INDEX;
                end else begin
                  res_status    <= ST_OK;
                  flag[idx_lo]  <= 1'b0;
                  tries[idx_lo] <= load_tries;
                end
              end
              CMD_REQ_ROLL: begin
                res_status <= ST_OK;
                pend       <= 1'b1;
                pend_tgt   <= idx_lo;
              end
              default: res_status <= ST_OK;
            endcase
          end
        end
        OP_SEL_INIT: begin
          ptr   <= IW'(1);
          key   <= '0;
          found <= 1'b0;
        end
        OP_SEL_STEP: begin
          if (rd_rank > key) begin
            key   <= rd_rank;
            pick  <= ptr;
            found <= 1'b1;
          end
          ptr <= ptr_next;
        end
        OP_SEL_FIN: begin
          res_ok <= 1'b1;
          if (found) begin
            flag[pick]  <= 1'b0;
            tries[pick] <= load_tries;
            res_status  <= ST_OK;
            res_slot    <= pick;
            res_tag     <= 3'(pick);
          end else begin
            res_status <= ST_NO_CAND;
            res_slot   <= cur;
            res_tag    <= 3'(cur);
          end
        end
        OP_ROLL_INIT: begin
          pick <= roll_src;
          key  <= rd_rank;
          ptr  <= '0;
        end
        OP_ROLL_STEP: begin
          if (rd_rank <= key) begin
            rank[ptr] <= rd_rank + IW'(1);
          end
          ptr <= ptr_next;
        end
        OP_ROLL_FIN: begin
          rank[pick] <= '0;
          pend       <= 1'b0;
          pend_tgt   <= '0;
          cur        <= pick;
          res_status <= ST_OK;
          res_slot   <= pick;
          res_tag    <= 3'(pick);
          res_ok     <= 1'b1;
        end
        OP_REV_INIT: begin
          ptr   <= '0;
          key   <= lowest;
          found <= 1'b0;
        end
        OP_REV_STEP: begin
          // best successful fallback, later slot wins a tie
          if (rd_flag && rd_rank != '0 && rd_rank <= key) begin
            key   <= rd_rank;
            pick  <= ptr;
            found <= 1'b1;
          end
          ptr <= ptr_next;
        end
        OP_REV_NOCAND, OP_SHOW_CUR: begin
          res_status <= (ctl.op == OP_REV_NOCAND) ? ST_NO_CAND : ST_OK;
          res_slot   <= cur;
          res_tag    <= 3'(cur);
          res_ok     <= 1'b1;
        end
        OP_REV_SHIFT: begin
          if (rd_rank >= key && rd_rank <= lowest) begin
            rank[ptr] <= rd_rank - IW'(1);
          end
          ptr <= ptr_next;
        end
        OP_REV_FIX_CUR: begin
          rank[cur] <= lowest;
          flag[cur] <= 1'b0;
        end
        OP_REV_FIX_NEW: begin
          rank[pick] <= '0;
          cur        <= pick;
          res_status <= ST_OK;
          res_slot   <= pick;
          res_tag    <= 3'(pick);
          res_ok     <= 1'b1;
        end
        OP_BAD_TARGET: begin
          res_status <= ST_BAD_INDEX;
          res_slot   <= pend_tgt;
          res_tag    <= 3'(pend_tgt);
          res_ok     <= 1'b0;
        end
        OP_REPORT: begin
          status          <= res_status;
          result_slot     <= res_tag;
          slot_successful <= res_ok & rd_flag;
          slot_tries_left <= res_ok ? 4'(rd_tries) : 4'd0;
          slot_priority   <= res_ok ? 3'(rd_rank) : 3'd0;
          current_slot    <= 3'(cur);
          restart_pending <= pend;
        end
        default: ;
      endcase
    end
  end

  a_cur_rank_zero: assert property (@(posedge clk) disable iff (rst)
    ctl.op == OP_REPORT |-> rank[cur] == '0)
    else $error("current slot does not hold rank zero at report");

  a_pend_target_in_range: assert property (@(posedge clk) disable iff (rst)
    pend |-> st.tgt_ok)
    else $error("pending target outside slots in use");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_SEL_STEP || ctl.op == OP_ROLL_STEP || ctl.op == OP_REV_STEP ||
     ctl.op == OP_REV_SHIFT) |-> 8'(ptr) < 8'(active))
    else $error("walk pointer beyond slots in use");

endmodule

// File: hw/rtl/usp_ctrl.sv
module usp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output usp_pkg::dp_cmd_t  ctl,
  input  usp_pkg::dp_stat_t st
);
  import usp_pkg::*;

  localparam logic [3:0] S_IDLE        = 4'd0;
  localparam logic [3:0] S_DISPATCH    = 4'd1;
  localparam logic [3:0] S_SEL_SCAN    = 4'd2;
  localparam logic [3:0] S_SEL_FIN     = 4'd3;
  localparam logic [3:0] S_ROLL_SCAN   = 4'd4;
  localparam logic [3:0] S_ROLL_FIN    = 4'd5;
  localparam logic [3:0] S_REV_SCAN    = 4'd6;
  localparam logic [3:0] S_REV_CHECK   = 4'd7;
  localparam logic [3:0] S_REV_SHIFT   = 4'd8;
  localparam logic [3:0] S_REV_FIX_CUR = 4'd9;
  localparam logic [3:0] S_REV_FIX_NEW = 4'd10;
  localparam logic [3:0] S_REPORT      = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid_next;
  logic       fire;

  assign in_ready = (state == S_IDLE);
  assign fire     = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    ctl.op         = OP_NOP;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op     = OP_LATCH;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.cmd)
          CMD_RESET_ALL: begin
            ctl.op     = OP_RESET_ALL;
            state_next = S_REPORT;
          end
          CMD_SELECT: begin
            ctl.op     = OP_SEL_INIT;
            state_next = S_SEL_SCAN;
          end
          CMD_REVERT: begin
            ctl.op     = OP_REV_INIT;
            state_next = S_REV_SCAN;
          end
          CMD_ROLL_PEND: begin
            if (!st.pend) begin
              ctl.op     = OP_SHOW_CUR;
              state_next = S_REPORT;
            end else if (!st.tgt_ok) begin
              ctl.op     = OP_BAD_TARGET;
              state_next = S_REPORT;
            end else begin
              ctl.op     = OP_ROLL_INIT;
              state_next = S_ROLL_SCAN;
            end
          end
          CMD_ROLL_NOW: begin
            if (st.idx_ok) begin
              ctl.op     = OP_ROLL_INIT;
              state_next = S_ROLL_SCAN;
            end else begin
              ctl.op     = OP_EXEC;
              state_next = S_REPORT;
            end
          end
          default: begin
            ctl.op     = OP_EXEC;
            state_next = S_REPORT;
          end
        endcase
      end
      S_SEL_SCAN: begin
        ctl.op = OP_SEL_STEP;
        if (st.last) state_next = S_SEL_FIN;
      end
      S_SEL_FIN: begin
        ctl.op     = OP_SEL_FIN;
        state_next = S_REPORT;
      end
      S_ROLL_SCAN: begin
        ctl.op = OP_ROLL_STEP;
        if (st.last) state_next = S_ROLL_FIN;
      end
      S_ROLL_FIN: begin
        ctl.op     = OP_ROLL_FIN;
        state_next = S_REPORT;
      end
      S_REV_SCAN: begin
        ctl.op = OP_REV_STEP;
        if (st.last) state_next = S_REV_CHECK;
      end
      S_REV_CHECK: begin
        if (st.found) begin
          state_next = S_REV_SHIFT;
        end else begin
          ctl.op     = OP_REV_NOCAND;
          state_next = S_REPORT;
        end
      end
      S_REV_SHIFT: begin
        ctl.op = OP_REV_SHIFT;
        if (st.last) state_next = S_REV_FIX_CUR;
      end
      S_REV_FIX_CUR: begin
        ctl.op     = OP_REV_FIX_CUR;
        state_next = S_REV_FIX_NEW;
      end
      S_REV_FIX_NEW: begin
        ctl.op     = OP_REV_FIX_NEW;
        state_next = S_REPORT;
      end
      S_REPORT: begin
        if (fire) begin
          ctl.op         = OP_REPORT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_result_from_report: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_REPORT))
    else $error("result word raised outside report");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in work");

  a_report_waits: assert property (@(posedge clk) disable iff (rst)
    state == S_REPORT && out_valid && !out_ready |=> state == S_REPORT)
    else $error("result overwritten before it was taken");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import usp_pkg::*;

  // register map: 4-bit registers at byte addresses 4*i
  localparam logic [2:0] ADDR_SLOT_COUNT = 3'd0;
  localparam logic [2:0] ADDR_MAX_TRIES  = 3'd4;

  // command codes the block treats as a plain query
  localparam logic [3:0] CMD_SPARE_LO = 4'd10;
  localparam logic [3:0] CMD_SPARE_HI = 4'd15;

  localparam int TABLE_SLOTS  = 8;
  localparam int PHASE_WORDS  = 165;  // random command words per register setting
  localparam int QUIET_LIMIT  = 600;  // cycles with nothing moving before giving up
  localparam int SETTLE_TICKS = 30;   // longest walk (revert over 8 slots) plus margin

  // one result word, in the order of the response channel fields
  typedef struct packed {
    logic [1:0] status;
    logic [2:0] slot;
    logic       ok;
    logic [3:0] tries;
    logic [2:0] prio;
    logic [2:0] cur;
    logic       pend;
  } slot_report_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  usp_cmd_if cmd_if ();
  usp_rsp_if rsp_if ();

  update_slot_priority_manager DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd_ch  (cmd_if),
    .rsp_ch  (rsp_if)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // slot table mirror: registers, latched slot count and the table itself
  // ---------------------------------------------------------------------------
  logic [3:0] reg_slot_count;
  logic [3:0] reg_max_tries;
  int         slots_in_use;
  logic       ok_flag [TABLE_SLOTS];
  logic [3:0] tries   [TABLE_SLOTS];
  logic [2:0] rank    [TABLE_SLOTS];
  logic [2:0] cur_slot;
  logic       roll_pending;
  logic [2:0] roll_target;

  // results still owed by the block, oldest first
  slot_report_t owed_reports [$];
  slot_report_t last_report;

  // bookkeeping
  int  errors;
  int  words_sent;
  int  words_checked;
  int  config_writes;
  int  settings_run;
  int  op_count [16];
  int  status_seen [4];
  bit  calm;       // stretch with no idling on either side
  int  stall_left;
  int  quiet_cycles;

  // fields of one slot as the block reports them after a command
  function automatic slot_report_t slot_report(logic [1:0] st, logic [3:0] slot, bit live);
    slot_report_t r;
    r.status = st;
    r.slot   = slot[2:0];
    r.ok     = live ? ok_flag[slot[2:0]] : 1'b0;
    r.tries  = live ? tries[slot[2:0]] : 4'd0;
    r.prio   = live ? rank[slot[2:0]] : 3'd0;
    r.cur    = cur_slot;
    r.pend   = roll_pending;
    return r;
  endfunction

  // rebuild the table from the registers, as at reset and on reset all
  function automatic void latch_table();
    int n;
    int i;
    n = reg_slot_count;
    if (n < 2) n = 2;
    if (n > TABLE_SLOTS) n = TABLE_SLOTS;
    slots_in_use = n;
    for (i = 0; i < TABLE_SLOTS; i++) begin
      ok_flag[i] = 1'b0;
      tries[i]   = reg_max_tries;
      rank[i]    = i[2:0];
    end
    ok_flag[0]   = 1'b1;
    cur_slot     = 3'd0;
    roll_pending = 1'b0;
    roll_target  = 3'd0;
  endfunction

  // promote a slot to rank 0, pushing the ranks it jumps over down by one
  function automatic void promote_slot(logic [2:0] t);
    logic [2:0] old;
    int i;
    old = rank[t];
    for (i = 0; i < slots_in_use; i++)
      if (rank[i] <= old) rank[i] = rank[i] + 3'd1;
    rank[t]      = 3'd0;
    roll_pending = 1'b0;
    roll_target  = 3'd0;
    cur_slot     = t;
  endfunction

  // apply one command word to the mirror and return the word the block owes
  function automatic slot_report_t run_slot_cmd(logic [3:0] op, logic [3:0] idx);
    logic       in_use;
    logic [2:0] s;
    int         i;
    int         hit;
    int         best;
    int         lowest;
    int         fb;
    in_use = (idx < slots_in_use);
    s      = idx[2:0];
    case (op)
      CMD_DECREMENT: begin
        if (in_use) begin
          if (tries[s] == 4'd0) return slot_report(ST_NO_TRIES, idx, 1'b1);
          tries[s] = tries[s] - 4'd1;
        end
      end
      CMD_MARK_OK: begin
        if (in_use) ok_flag[s] = 1'b1;
      end
      CMD_CLEAR: begin
        if (in_use) begin
          // the system slot is never cleared
          if (idx == 4'd0) return slot_report(ST_BAD_INDEX, 4'd0, 1'b1);
          ok_flag[s] = 1'b0;
          tries[s]   = reg_max_tries;
        end
      end
      CMD_SELECT: begin
        best = 0;
        hit  = -1;
        for (i = 1; i < slots_in_use; i++)
          if (rank[i] > best) begin
            best = rank[i];
            hit  = i;
          end
        if (hit < 0) return slot_report(ST_NO_CAND, {1'b0, cur_slot}, 1'b1);
        ok_flag[hit] = 1'b0;
        tries[hit]   = reg_max_tries;
        return slot_report(ST_OK, hit[3:0], 1'b1);
      end
      CMD_REQ_ROLL: begin
        if (in_use) begin
          roll_pending = 1'b1;
          roll_target  = s;
        end
      end
      CMD_ROLL_PEND: begin
        if (!roll_pending) return slot_report(ST_OK, {1'b0, cur_slot}, 1'b1);
        if (roll_target >= slots_in_use)
          return slot_report(ST_BAD_INDEX, {1'b0, roll_target}, 1'b0);
        hit = roll_target;
        promote_slot(roll_target);
        return slot_report(ST_OK, hit[3:0], 1'b1);
      end
      CMD_ROLL_NOW: begin
        if (in_use) promote_slot(s);
      end
      CMD_REVERT: begin
        lowest = slots_in_use - 1;
        fb     = lowest;
        hit    = -1;
        for (i = 0; i < slots_in_use; i++)
          if (ok_flag[i] && rank[i] > 0 && rank[i] <= fb) begin
            fb  = rank[i];
            hit = i;
          end
        if (hit < 0) return slot_report(ST_NO_CAND, {1'b0, cur_slot}, 1'b1);
        for (i = 0; i < slots_in_use; i++)
          if (rank[i] >= fb && rank[i] <= lowest) rank[i] = rank[i] - 3'd1;
        rank[cur_slot]    = lowest[2:0];
        ok_flag[cur_slot] = 1'b0;
        rank[hit]         = 3'd0;
        cur_slot          = hit[2:0];
        return slot_report(ST_OK, hit[3:0], 1'b1);
      end
      CMD_RESET_ALL: begin
        latch_table();
        return slot_report(ST_OK, {1'b0, cur_slot}, 1'b1);
      end
      default: ;
    endcase
    if (!in_use) return slot_report(ST_BAD_INDEX, idx, 1'b0);
    return slot_report(ST_OK, idx, 1'b1);
  endfunction

  // idle cycles drawn per word, zero throughout a calm stretch
  function int idle_gap();
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  // any 4-bit index
  function automatic logic [3:0] any_index();
    return 4'($urandom_range(0, 15));
  endfunction

  // mostly slots in use, now and then any 4-bit index
  function automatic logic [3:0] pick_index();
    if ($urandom_range(0, 9) == 0) return any_index();
    return 4'($urandom_range(0, slots_in_use - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // command side: one word per call, valid left high on acceptance so that a
  // back-to-back word never lowers and raises it in the same step
  // ---------------------------------------------------------------------------
  task automatic send_word(logic [3:0] op, logic [3:0] idx);
    int gap;
    if ($urandom_range(0, 39) == 0) calm = !calm;
    gap = idle_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.cmd        <= op;
    cmd_if.slot_index <= idx;
    do @(posedge clk); while (!cmd_if.ready);
    last_report = run_slot_cmd(op, idx);
    owed_reports.push_back(last_report);
    words_sent++;
    op_count[op]++;
  endtask

  // drop valid in the step of the last acceptance and wait until all results are in
  task automatic drain_words();
    cmd_if.valid <= 1'b0;
    while (owed_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [2:0] addr, logic [3:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= {28'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_SLOT_COUNT) reg_slot_count = value;
    else reg_max_tries = value;
    config_writes++;
    @(posedge clk);
  endtask

  task automatic read_reg(logic [2:0] addr);
    logic [3:0] want;
    want    = (addr == ADDR_SLOT_COUNT) ? reg_slot_count : reg_max_tries;
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // prdata sampled in the access cycle, before this edge takes effect
    if (prdata[3:0] !== want) begin
      errors++;
      $display("%0t: register at 0x%0h read back: expected %0d actual %0d",
               $time, addr, want, prdata[3:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // block must be idle here; slot count only bites at the next reset all
  task automatic set_registers(logic [3:0] count, logic [3:0] max_try);
    write_reg(ADDR_SLOT_COUNT, count);
    write_reg(ADDR_MAX_TRIES, max_try);
    read_reg(ADDR_SLOT_COUNT);
    read_reg(ADDR_MAX_TRIES);
    settings_run++;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure and the field by field comparison
  // ---------------------------------------------------------------------------
  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d actual %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    slot_report_t want;
    slot_report_t got;
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.status = rsp_if.status;
        got.slot   = rsp_if.result_slot;
        got.ok     = rsp_if.slot_successful;
        got.tries  = rsp_if.slot_tries_left;
        got.prio   = rsp_if.slot_priority;
        got.cur    = rsp_if.current_slot;
        got.pend   = rsp_if.restart_pending;
        if (owed_reports.size() == 0) begin
          errors++;
          $display("%0t: result word with no command outstanding: expected none actual %h",
                   $time, got);
        end else begin
          want = owed_reports.pop_front();
          check_field("status", want.status, got.status);
          check_field("result_slot", want.slot, got.slot);
          check_field("slot_successful", want.ok, got.ok);
          check_field("slot_tries_left", want.tries, got.tries);
          check_field("slot_priority", want.prio, got.prio);
          check_field("current_slot", want.cur, got.cur);
          check_field("restart_pending", want.pend, got.pend);
        end
        words_checked++;
        status_seen[got.status]++;
        stall_left = idle_gap();
      end else if (stall_left > 0) begin
        stall_left--;
      end
      rsp_if.ready <= (stall_left == 0);
    end
  end

  // watchdog: nothing moving on any port for too long
  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d results still owed",
               $time, quiet_cycles, owed_reports.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // table straight out of reset: edge indexes, a spare code, nothing to revert to
  task automatic test_reset_table();
    send_word(CMD_QUERY, 4'd0);
    send_word(CMD_QUERY, 4'd7);
    send_word(CMD_QUERY, 4'd15);
    send_word(CMD_SPARE_HI, 4'd8);
    send_word(CMD_REVERT, 4'd0);
    drain_words();
  endtask

  // per-slot edits: run tries out, mark, clear incl. the refused system slot
  task automatic test_slot_edits();
    repeat (4) send_word(CMD_DECREMENT, 4'd1);
    send_word(CMD_DECREMENT, 4'd12);
    send_word(CMD_MARK_OK, 4'd2);
    send_word(CMD_MARK_OK, 4'd9);
    send_word(CMD_CLEAR, 4'd0);
    send_word(CMD_CLEAR, 4'd9);
    send_word(CMD_CLEAR, 4'd1);
    drain_words();
  endtask

  // roll forward paths, a replaced request and a revert that finds a fallback
  task automatic test_roll_and_revert();
    send_word(CMD_ROLL_PEND, 4'd5);
    send_word(CMD_SELECT, 4'd0);
    send_word(CMD_REQ_ROLL, 4'd3);
    send_word(CMD_REQ_ROLL, 4'd7);
    send_word(CMD_ROLL_PEND, 4'd0);
    send_word(CMD_MARK_OK, 4'd7);
    send_word(CMD_ROLL_NOW, 4'd2);
    send_word(CMD_REVERT, 4'd0);
    send_word(CMD_SPARE_LO, 4'd3);
    drain_words();
  endtask

  // register extremes: counts below and above range, zero and full tries
  task automatic test_register_extremes();
    set_registers(4'd0, 4'd0);
    send_word(CMD_RESET_ALL, 4'd15);
    send_word(CMD_QUERY, 4'd2);
    send_word(CMD_SELECT, 4'd0);
    send_word(CMD_DECREMENT, 4'd1);
    drain_words();
    set_registers(4'd15, 4'd15);
    send_word(CMD_RESET_ALL, 4'd0);
    send_word(CMD_QUERY, 4'd7);
    drain_words();
  endtask

  // one update attempt: pick a slot, roll to it, burn tries, maybe fall back
  task automatic update_attempt();
    logic [3:0] chosen;
    int k;
    send_word(CMD_SELECT, any_index());
    chosen = {1'b0, last_report.slot};
    if ($urandom_range(0, 1) == 0) begin
      if ($urandom_range(0, 3) == 0) send_word(CMD_REQ_ROLL, pick_index());
      send_word(CMD_REQ_ROLL, chosen);
      send_word(CMD_ROLL_PEND, any_index());
    end else begin
      send_word(CMD_ROLL_NOW, chosen);
    end
    k = $urandom_range(0, 4);
    repeat (k) send_word(CMD_DECREMENT, chosen);
    if ($urandom_range(0, 1) == 0) send_word(CMD_MARK_OK, chosen);
    if ($urandom_range(0, 4) < 2) send_word(CMD_REVERT, any_index());
  endtask

  // one loose command, weighted towards the ones that move the table
  task automatic loose_command();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) send_word(CMD_QUERY, pick_index());
    else if (pick < 22) send_word(CMD_DECREMENT, pick_index());
    else if (pick < 36) send_word(CMD_MARK_OK, pick_index());
    else if (pick < 44) send_word(CMD_CLEAR, pick_index());
    else if (pick < 54) send_word(CMD_SELECT, any_index());
    else if (pick < 66) send_word(CMD_REQ_ROLL, pick_index());
    else if (pick < 76) send_word(CMD_ROLL_PEND, any_index());
    else if (pick < 84) send_word(CMD_ROLL_NOW, pick_index());
    else if (pick < 95) send_word(CMD_REVERT, any_index());
    else if (pick < 97) send_word(CMD_RESET_ALL, any_index());
    else send_word(4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), any_index());
  endtask

  // random traffic under a run of register settings, extremes first
  task automatic test_random_traffic();
    logic [3:0] count_list [8];
    logic [3:0] tries_list [8];
    int p;
    int first;
    count_list = '{4'd2, 4'd8, 4'd1, 4'd15, 4'd5, 4'd3, 4'd0, 4'd7};
    tries_list = '{4'd1, 4'd15, 4'd0, 4'd3, 4'd2, 4'd7, 4'd4, 4'd12};
    for (p = 0; p < 10; p++) begin
      if (p < 8) set_registers(count_list[p], tries_list[p]);
      else set_registers(any_index(), any_index());
      send_word(CMD_RESET_ALL, any_index());
      first = words_sent;
      while (words_sent - first < PHASE_WORDS) begin
        if ($urandom_range(0, 9) < 6) update_attempt();
        else loose_command();
      end
      drain_words();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = 3'd0;
    pwdata            = 32'd0;
    cmd_if.valid      = 1'b0;
    cmd_if.cmd        = CMD_QUERY;
    cmd_if.slot_index = 4'd0;
    rsp_if.ready      = 1'b0;
    errors            = 0;
    words_sent        = 0;
    words_checked     = 0;
    config_writes     = 0;
    settings_run      = 0;
    stall_left        = 0;
    quiet_cycles      = 0;
    calm              = 1'b0;
    foreach (op_count[i]) op_count[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // mirror starts from the power-on register values
    reg_slot_count = 4'd8;
    reg_max_tries  = 4'd3;
    latch_table();

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_table();
    test_slot_edits();
    test_roll_and_revert();
    test_register_extremes();
    test_random_traffic();

    drain_words();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (owed_reports.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, owed_reports.size());
    end

    $display("covered %0d command words (%0d results checked) under %0d register settings",
             words_sent, words_checked, settings_run);
    $display("status ok/index/tries/candidate seen %0d/%0d/%0d/%0d, %0d register writes",
             status_seen[ST_OK], status_seen[ST_BAD_INDEX], status_seen[ST_NO_TRIES],
             status_seen[ST_NO_CAND], config_writes);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: update_slot_priority_manager.f
hw/rtl/usp_pkg.sv
hw/rtl/usp_cmd_if.sv
hw/rtl/usp_rsp_if.sv
hw/rtl/usp_dp.sv
hw/rtl/usp_ctrl.sv
hw/rtl/update_slot_priority_manager.sv
tb/testbench.sv
